@@ hdl/ubx_pkg.sv @@
// shared types and codes for the ubx frame parser
package ubx_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD      = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } ubx_phase_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
  } ubx_result_t;

endpackage

@@ hdl/ubx_frame_parser.sv @@
// ubx frame parser top level: handshakes, input and result registers, max_length register
// a result word passes through the input register and then the result register before it is offered
// throughput: one byte per cycle while the result register is not stalled, as ubx_fsm updates its state once per byte
// a stalled result holds the input register and the ubx_fsm state; bytes flow again once it is taken
// rst (synchronous) returns the parser to hunting for sync, clears frame state and sums
// rst also loads max_length with 1024 and empties both registers
module ubx_frame_parser
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] length,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_index
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic [15:0] max_length;
  logic        step;
  ubx_result_t res;

  // the held byte is processed when the result register is free or being emptied
  assign step      = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  ubx_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (hold_byte),
    .max_length (max_length),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      kind       <= res.kind;
      msg_class  <= res.msg_class;
      msg_id     <= res.msg_id;
      length     <= res.length;
      data_byte  <= res.data_byte;
      byte_index <= res.byte_index;
    end
  end

endmodule

@@ hdl/ubx_fsm.sv @@
// frame state, running fletcher sum and per-byte result logic
module ubx_fsm
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_length,
  output ubx_result_t res
);

  ubx_phase_t  phase, phase_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  received_a, received_a_next;

  logic [7:0]  fold_a, fold_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      frame_class  <= 8'd0;
      frame_id     <= 8'd0;
      frame_length <= 16'd0;
      byte_count   <= 16'd0;
      sum_a        <= 8'd0;
      sum_b        <= 8'd0;
      received_a   <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      frame_class  <= frame_class_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      received_a   <= received_a_next;
    end
  end

  always_comb begin
    fold_a    = sum_a + rx_byte;
    fold_b    = sum_b + fold_a;
    len_full  = {rx_byte, frame_length[7:0]};
    count_inc = byte_count + 16'd1;

    phase_next        = phase;
    frame_class_next  = frame_class;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    received_a_next   = received_a;

    res.valid      = 1'b0;
    res.kind       = KIND_DATA;
    res.msg_class  = frame_class;
    res.msg_id     = frame_id;
    res.length     = frame_length;
    res.data_byte  = 8'd0;
    res.byte_index = 16'd0;

    unique case (phase)
      PH_SYNC2: begin
        phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        // sum restarts with the class byte
        frame_class_next = rx_byte;
        sum_a_next       = rx_byte;
        sum_b_next       = rx_byte;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        frame_id_next = rx_byte;
        sum_a_next    = fold_a;
        sum_b_next    = fold_b;
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {8'd0, rx_byte};
        sum_a_next        = fold_a;
        sum_b_next        = fold_b;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_next = len_full;
        sum_a_next        = fold_a;
        sum_b_next        = fold_b;
        byte_count_next   = 16'd0;
        res.length        = len_full;
        if (len_full > max_length) begin
          phase_next = PH_SYNC1;
          res.valid  = 1'b1;
          res.kind   = KIND_TOO_LONG;
        end else begin
          phase_next = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.valid       = 1'b1;
        res.kind        = KIND_DATA;
        res.data_byte   = rx_byte;
        res.byte_index  = byte_count;
        sum_a_next      = fold_a;
        sum_b_next      = fold_b;
        byte_count_next = count_inc;
        if (count_inc >= frame_length) begin
          phase_next = PH_CK_A;
        end
      end
      PH_CK_A: begin
        received_a_next = rx_byte;
        phase_next      = PH_CK_B;
      end
      PH_CK_B: begin
        phase_next = PH_SYNC1;
        res.valid  = 1'b1;
        res.kind   = ((received_a == sum_a) && (rx_byte == sum_b)) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
        // hunting, and any stray phase code
        phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  a_data_in_payload: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_DATA) |-> phase == PH_PAYLOAD)
    else $error("payload word outside payload phase");

  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_count < frame_length)
    else $error("byte count reached declared length inside payload");

  a_end_back_to_hunt: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && (res.kind != KIND_DATA) |=> phase == PH_SYNC1)
    else $error("frame end did not return to hunting");

endmodule

@@ verif/ubx_frame_parser_test.sv @@
// self-checking testbench for the ubx frame parser: scripted frames, then random byte streams
`timescale 1ns / 1ps

module ubx_frame_parser_test
  import ubx_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_LEN = 27;
  localparam int ITEMS_PER_SETTING = 325;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  data;
    logic [15:0] idx;
  } frame_word_t;

  typedef struct {
    logic [7:0]  b;
    bit          pinned;
    frame_word_t word;
  } script_row_t;

  localparam frame_word_t NO_WORD = '0;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] length;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;

  // scripted rows may carry a typed-in result that replaces the predicted one
  logic        pin_valid = 1'b0;
  frame_word_t pin_word = '0;

  ubx_frame_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .msg_class  (msg_class),
    .msg_id     (msg_id),
    .length     (length),
    .data_byte  (data_byte),
    .byte_index (byte_index)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // parser shadow state
  ubx_phase_t  hunt_phase = PH_SYNC1;
  logic [7:0]  cur_class = 8'h00;
  logic [7:0]  cur_id = 8'h00;
  logic [15:0] cur_len = 16'h0000;
  logic [15:0] pay_count = 16'h0000;
  logic [7:0]  fl_a = 8'h00;
  logic [7:0]  fl_b = 8'h00;
  logic [7:0]  rcv_a = 8'h00;
  logic [15:0] limit_model = MAX_LENGTH_RESET;

  frame_word_t pending_words[$];
  int          mismatch_count = 0;
  int          idle_count = 0;
  int          n_data = 0;
  int          n_good = 0;
  int          n_bad = 0;
  int          n_long = 0;
  int          items_sent = 0;
  int          settings_seen = 1;
  int          cur_limit = MAX_LENGTH_RESET;
  bit          quiet_frame = 1'b0;

  frame_word_t got_word;
  frame_word_t want_word;
  frame_word_t next_word;
  bit          produced;

  task fold_sum(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  task parse_byte(input logic [7:0] b, output bit made, output frame_word_t w);
    made = 1'b0;
    w = NO_WORD;
    case (hunt_phase)
      PH_SYNC2: begin
        hunt_phase = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        cur_class = b;
        fl_a = 8'h00;
        fl_b = 8'h00;
        fold_sum(b);
        hunt_phase = PH_ID;
      end
      PH_ID: begin
        cur_id = b;
        fold_sum(b);
        hunt_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, b};
        fold_sum(b);
        hunt_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len[15:8] = b;
        fold_sum(b);
        pay_count = 16'h0000;
        if (cur_len > limit_model) begin
          hunt_phase = PH_SYNC1;
          made = 1'b1;
          w = '{KIND_TOO_LONG, cur_class, cur_id, cur_len, 8'h00, 16'h0000};
        end else begin
          hunt_phase = (cur_len == 16'h0000) ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        made = 1'b1;
        w = '{KIND_DATA, cur_class, cur_id, cur_len, b, pay_count};
        fold_sum(b);
        pay_count = pay_count + 16'd1;
        if (pay_count >= cur_len) hunt_phase = PH_CK_A;
      end
      PH_CK_A: begin
        rcv_a = b;
        hunt_phase = PH_CK_B;
      end
      PH_CK_B: begin
        made = 1'b1;
        w = '{((rcv_a == fl_a) && (b == fl_b)) ? KIND_GOOD : KIND_BAD,
              cur_class, cur_id, cur_len, 8'h00, 16'h0000};
        hunt_phase = PH_SYNC1;
      end
      default: begin
        hunt_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  endtask

  task check_word(input frame_word_t got, input frame_word_t want);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.cls !== want.cls) begin
      $error("msg_class: expected %0h, got %0h", want.cls, got.cls);
      mismatch_count++;
    end
    if (got.id !== want.id) begin
      $error("msg_id: expected %0h, got %0h", want.id, got.id);
      mismatch_count++;
    end
    if (got.len !== want.len) begin
      $error("length: expected %0d, got %0d", want.len, got.len);
      mismatch_count++;
    end
    if (got.data !== want.data) begin
      $error("data_byte: expected %0h, got %0h", want.data, got.data);
      mismatch_count++;
    end
    if (got.idx !== want.idx) begin
      $error("byte_index: expected %0d, got %0d", want.idx, got.idx);
      mismatch_count++;
    end
  endtask

  // checking and prediction share one process so the order within an edge is fixed
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_word = '{kind, msg_class, msg_id, length, data_byte, byte_index};
        if (pending_words.size() == 0) begin
          $error("result word with nothing pending: kind %0d", kind);
          mismatch_count++;
        end else begin
          want_word = pending_words.pop_front();
          check_word(got_word, want_word);
          case (want_word.kind)
            KIND_DATA: n_data++;
            KIND_GOOD: n_good++;
            KIND_BAD:  n_bad++;
            default:   n_long++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) limit_model = cfg_data;
      if (in_valid && in_ready) begin
        parse_byte(rx_byte, produced, next_word);
        if (pin_valid) pending_words.push_back(pin_word);
        else if (produced) pending_words.push_back(next_word);
      end
      if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver side: short and long stalls, with calm stretches
  int calm_left = 0;
  int hold_left = 0;
  int ready_pick;

  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
      out_ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 2) begin
        calm_left <= $urandom_range(50, 300);
        out_ready <= 1'b1;
      end else if (ready_pick < 20) begin
        hold_left <= $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else if (ready_pick < 23) begin
        hold_left <= $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task send_byte(input logic [7:0] b, input bit pinned, input frame_word_t pw);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_frame || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // hold the word until the parser takes it
    in_valid <= 1'b1;
    rx_byte <= b;
    pin_valid <= pinned;
    pin_word <= pw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task set_max_length(input logic [15:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    // sync, header and first checksum bytes give no word, so let the pipeline drain
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
    settings_seen++;
  endtask

  task send_random_frame();
    int          pick;
    int          len;
    int          n;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  b;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    bit          oversize;
    quiet_frame = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // line noise, often carrying a stray first sync byte
      n = $urandom_range(1, 6);
      repeat (n) begin
        b = ($urandom_range(0, 9) < 3) ? SYNC_FIRST : 8'($urandom_range(0, 255));
        send_byte(b, 1'b0, NO_WORD);
      end
      return;
    end
    send_byte(SYNC_FIRST, 1'b0, NO_WORD);
    if (pick < 10) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_SECOND) b = SYNC_FIRST;
      send_byte(b, 1'b0, NO_WORD);
      return;
    end
    send_byte(SYNC_SECOND, 1'b0, NO_WORD);
    cls = 8'($urandom_range(0, 255));
    id = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    oversize = 1'b0;
    if (pick < 15 && cur_limit < 65535) begin
      oversize = 1'b1;
      len = ($urandom_range(0, 1) == 0) ? cur_limit + 1 : $urandom_range(65535, cur_limit + 1);
    end else if (pick < 19) begin
      len = (cur_limit > 40) ? $urandom_range(41, (cur_limit < 300) ? cur_limit : 300)
                             : cur_limit;
    end else begin
      len = $urandom_range(0, (cur_limit < 12) ? cur_limit : 12);
    end
    ck_a = 8'h00;
    ck_b = 8'h00;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: b = cls;
        1: b = id;
        2: b = len[7:0];
        default: b = len[15:8];
      endcase
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b, 1'b0, NO_WORD);
    end
    if (oversize) return;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b, 1'b0, NO_WORD);
    end
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 0) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      else ck_b = ck_b ^ 8'($urandom_range(1, 255));
    end
    send_byte(ck_a, 1'b0, NO_WORD);
    send_byte(ck_b, 1'b0, NO_WORD);
  endtask

  script_row_t script [SCRIPT_LEN];

  initial begin
    script = '{
      // empty payload, good checksum
      '{8'hB5, 1'b0, NO_WORD}, '{8'h62, 1'b0, NO_WORD},
      '{8'h01, 1'b0, NO_WORD}, '{8'h02, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h03, 1'b0, NO_WORD},
      '{8'h0A, 1'b1, '{KIND_GOOD, 8'h01, 8'h02, 16'd0, 8'h00, 16'd0}},
      // broken sync pair: the second sync byte is not taken as a fresh start
      '{8'hB5, 1'b0, NO_WORD}, '{8'hB5, 1'b0, NO_WORD}, '{8'h62, 1'b0, NO_WORD},
      // one above the reset length limit
      '{8'hB5, 1'b0, NO_WORD}, '{8'h62, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
      '{8'h01, 1'b0, NO_WORD},
      '{8'h04, 1'b1, '{KIND_TOO_LONG, 8'hFF, 8'hFF, 16'd1025, 8'h00, 16'd0}},
      // two payload bytes at the extremes, then a wrong checksum
      '{8'hB5, 1'b0, NO_WORD}, '{8'h62, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h02, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b1, '{KIND_DATA, 8'h00, 8'h00, 16'd2, 8'h00, 16'd0}},
      '{8'hFF, 1'b1, '{KIND_DATA, 8'h00, 8'h00, 16'd2, 8'hFF, 16'd1}},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b1, '{KIND_BAD, 8'h00, 8'h00, 16'd2, 8'h00, 16'd0}}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < SCRIPT_LEN; r++) send_byte(script[r].b, script[r].pinned, script[r].word);
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: set_max_length(16'h0000);
        2: set_max_length(16'hFFFF);
        3: set_max_length(16'd7);
        4: set_max_length(16'($urandom_range(20, 300)));
        5: set_max_length(MAX_LENGTH_RESET);
        default: ;
      endcase
      while (items_sent < SCRIPT_LEN + (p + 1) * ITEMS_PER_SETTING) send_random_frame();
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (8) @(posedge clk);
    $display("run fed %0d bytes under %0d max_length settings", items_sent, settings_seen);
    $display("checked %0d payload words, %0d good, %0d failed-checksum, %0d oversize frames",
             n_data, n_good, n_bad, n_long);
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ubx_pkg.sv
hdl/ubx_fsm.sv
hdl/ubx_frame_parser.sv
verif/ubx_frame_parser_test.sv
